// ===== rtl/lsc_pkg.sv =====
`default_nettype none
package lsc_pkg;

  localparam int COORD_W  = 32;
  localparam int RAD_W    = 31;
  // scaled values stay within [-2^30, 2^30)
  localparam int SCL_W    = 31;
  localparam int ACC_W    = 128;
  localparam int ROOT_W   = 63;
  localparam int QCAP_BIT = 34;
  localparam int DIV_W    = 98;

  // one pass through the shared multiply-accumulate unit
  typedef struct packed {
    logic [31:0] opa;
    logic [31:0] opb;
    logic [1:0]  sh;   // product shifted left by 32*sh
    logic        neg;  // subtract instead of add
  } lsc_mul_t;

endpackage
`default_nettype wire

// ===== rtl/line_sphere_clip_core.sv =====
`default_nettype none
// Channel  Dir  Handshake                     Payload
// in       in   in_tvalid / in_tready         in_tdata: two points, radius
// out      out  out_tvalid / out_tready       out_tdata: both ends, out_tuser: flags
//
// One line takes 10 MAC passes for A, B and C, 8 for the
// discriminant, 63 square root steps, then for each of six coordinates 2 MAC
// passes and 36 division steps on the shared 128-bit adder, plus bookkeeping.
// A miss skips the root and the divisions.
// in_tready is high only while the sequencer is idle; a finished result waits
// in the output register and the next line may start while it is pending.
// Synchronous active-low reset clears the sequencer, out_tvalid and the line
// counter.
module line_sphere_clip_core #(
  parameter int LINE_CAPACITY = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, radius, pad
  input  wire logic [223:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z
  output logic [191:0]      out_tdata,
  // missed_sphere, line_index[9:0], store_full, pad
  output logic [15:0]       out_tuser
);

  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ABC  = 3'd1;
  localparam logic [2:0] S_DISC = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_EMUL = 3'd4;
  localparam logic [2:0] S_EDIV = 3'd5;
  localparam logic [2:0] S_EFIN = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam int ACC_W  = lsc_pkg::ACC_W;
  localparam int ROOT_W = lsc_pkg::ROOT_W;
  localparam int DIV_W  = lsc_pkg::DIV_W;

  function automatic logic [31:0] mag31(input logic signed [30:0] s);
    logic [30:0] n;
    n = s[30] ? (~s + 31'd1) : s;
    return {1'b0, n};
  endfunction

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [2:0]  e_r, e_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic signed [31:0] px_r [3];
  logic signed [31:0] qx_r [3];
  logic [30:0] rad_r;
  logic [1:0]  k_r;
  logic [9:0]  idx_r;
  logic        full_r;
  logic        miss_r;

  logic [ACC_W-1:0] acc_r;
  logic [63:0] a_r;
  logic signed [63:0] b_r, c_r;
  logic [65:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic signed [64:0] np_r, nm_r;
  logic [DIV_W-1:0] div_r;
  logic [34:0] q_r;
  logic        ovf_r;
  logic [31:0] res_r [6];

  logic         out_valid_r;
  logic [191:0] out_data_r;
  logic [15:0]  out_user_r;

  // ---------------------------------------------------------------- operands
  logic signed [32:0] x33_w [3];
  logic signed [32:0] v33_w [3];
  logic signed [30:0] xs_w [3];
  logic signed [30:0] vs_w [3];
  logic signed [30:0] rs_w;
  logic [31:0] vabs_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x33_w[i]  = {px_r[i][31], px_r[i]};
      v33_w[i]  = {qx_r[i][31], qx_r[i]} - x33_w[i];
      xs_w[i]   = 31'(x33_w[i] >>> k_r);
      vs_w[i]   = 31'(v33_w[i] >>> k_r);
      vabs_w[i] = v33_w[i][32] ? 32'(-v33_w[i]) : 32'(v33_w[i]);
    end
    rs_w = 31'({2'b00, rad_r} >> k_r);
  end

  // input scale: bring every magnitude below 2^30
  logic signed [32:0] ix_w [3];
  logic signed [32:0] iv_w [3];
  logic [32:0] mor_w;
  logic [1:0]  k_w;

  always_comb begin
    mor_w = {2'b00, in_tdata[222:192]};
    for (int i = 0; i < 3; i++) begin
      ix_w[i] = {in_tdata[32*i+31], in_tdata[32*i +: 32]};
      iv_w[i] = {in_tdata[32*i+127], in_tdata[32*i+96 +: 32]} - ix_w[i];
      mor_w = mor_w | (ix_w[i][32] ? 33'(-ix_w[i]) : 33'(ix_w[i]))
                    | (iv_w[i][32] ? 33'(-iv_w[i]) : 33'(iv_w[i]));
    end
    priority if (mor_w[32]) k_w = 2'd3;
    else if (mor_w[31])     k_w = 2'd2;
    else if (mor_w[30])     k_w = 2'd1;
    else                    k_w = 2'd0;
  end

  // endpoint selection
  logic [1:0] ci_w;
  logic signed [64:0] n_w;
  logic [63:0] nabs_w;

  always_comb begin
    ci_w   = (e_r < 3'd3) ? e_r[1:0] : 2'(e_r - 3'd3);
    n_w    = (e_r < 3'd3) ? np_r : nm_r;
    nabs_w = n_w[64] ? 64'(-n_w) : 64'(n_w);
  end

  // ------------------------------------------------------- shared MAC unit
  lsc_pkg::lsc_mul_t mop_w;
  logic [63:0] babs_w, cabs_w;
  logic [63:0] prod_w;
  logic [ACC_W-1:0] term_w, opb_w, sum_w;
  logic cin_w;

  always_comb begin
    babs_w = b_r[63] ? 64'(-b_r) : 64'(b_r);
    cabs_w = c_r[63] ? 64'(-c_r) : 64'(c_r);
    mop_w  = '0;
    unique case (state_r)
      S_ABC: begin
        unique case (step_r[3:0])
          4'd0: mop_w = '{mag31(vs_w[0]), mag31(vs_w[0]), 2'd0, 1'b0};
          4'd1: mop_w = '{mag31(vs_w[1]), mag31(vs_w[1]), 2'd0, 1'b0};
          4'd2: mop_w = '{mag31(vs_w[2]), mag31(vs_w[2]), 2'd0, 1'b0};
          4'd3: mop_w = '{mag31(xs_w[0]), mag31(vs_w[0]), 2'd0, xs_w[0][30] ^ vs_w[0][30]};
          4'd4: mop_w = '{mag31(xs_w[1]), mag31(vs_w[1]), 2'd0, xs_w[1][30] ^ vs_w[1][30]};
          4'd5: mop_w = '{mag31(xs_w[2]), mag31(vs_w[2]), 2'd0, xs_w[2][30] ^ vs_w[2][30]};
          4'd6: mop_w = '{mag31(xs_w[0]), mag31(xs_w[0]), 2'd0, 1'b0};
          4'd7: mop_w = '{mag31(xs_w[1]), mag31(xs_w[1]), 2'd0, 1'b0};
          4'd8: mop_w = '{mag31(xs_w[2]), mag31(xs_w[2]), 2'd0, 1'b0};
          4'd9: mop_w = '{mag31(rs_w), mag31(rs_w), 2'd0, 1'b1};
          default: mop_w = '0;
        endcase
      end
      S_DISC: begin
        unique case (step_r[2:0])
          3'd0: mop_w = '{babs_w[31:0],  babs_w[31:0],  2'd0, 1'b0};
          3'd1: mop_w = '{babs_w[31:0],  babs_w[63:32], 2'd1, 1'b0};
          3'd2: mop_w = '{babs_w[63:32], babs_w[31:0],  2'd1, 1'b0};
          3'd3: mop_w = '{babs_w[63:32], babs_w[63:32], 2'd2, 1'b0};
          3'd4: mop_w = '{a_r[31:0],  cabs_w[31:0],  2'd0, ~c_r[63]};
          3'd5: mop_w = '{a_r[31:0],  cabs_w[63:32], 2'd1, ~c_r[63]};
          3'd6: mop_w = '{a_r[63:32], cabs_w[31:0],  2'd1, ~c_r[63]};
          3'd7: mop_w = '{a_r[63:32], cabs_w[63:32], 2'd2, ~c_r[63]};
          default: mop_w = '0;
        endcase
      end
      S_EMUL: begin
        if (step_r[0]) mop_w = '{nabs_w[63:32], vabs_w[ci_w], 2'd1, 1'b0};
        else           mop_w = '{nabs_w[31:0],  vabs_w[ci_w], 2'd0, 1'b0};
      end
      default: mop_w = '0;
    endcase

    prod_w = 64'(mop_w.opa) * 64'(mop_w.opb);
    term_w = {64'd0, prod_w} << {mop_w.sh, 5'd0};
    if (state_r == S_EDIV) begin
      opb_w = ~{{(ACC_W-DIV_W){1'b0}}, div_r};
      cin_w = 1'b1;
    end else begin
      opb_w = mop_w.neg ? ~term_w : term_w;
      cin_w = mop_w.neg;
    end
    sum_w = acc_r + opb_w + {{(ACC_W-1){1'b0}}, cin_w};
  end

  // ------------------------------------------------------------ square root
  logic [65:0] remt_w, trial_w, rdif_w;
  logic        rge_w;

  always_comb begin
    remt_w  = {rem_r[63:0], acc_r[125:124]};
    trial_w = {1'b0, root_r, 2'b01};
    rdif_w  = remt_w - trial_w;
    rge_w   = remt_w >= trial_w;
  end

  // ------------------------------------------------------------ endpoint sum
  logic [34:0] qf_w;
  logic signed [35:0] res36_w;
  logic [31:0] sat_w;

  always_comb begin
    qf_w = (ovf_r || (q_r > (35'd1 << lsc_pkg::QCAP_BIT)))
           ? (35'd1 << lsc_pkg::QCAP_BIT) : q_r;
    if (n_w[64] ^ v33_w[ci_w][32])
      res36_w = {{4{px_r[ci_w][31]}}, px_r[ci_w]} - {1'b0, qf_w};
    else
      res36_w = {{4{px_r[ci_w][31]}}, px_r[ci_w]} + {1'b0, qf_w};
    if (res36_w > 36'sd2147483647)       sat_w = 32'h7FFF_FFFF;
    else if (res36_w < -36'sd2147483648) sat_w = 32'h8000_0000;
    else                                 sat_w = res36_w[31:0];
  end

  // --------------------------------------------------------------- sequencer
  logic in_xfer_w, out_free_w;
  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer_w  = in_tvalid && in_tready;
  assign out_free_w = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 6'd1;
    e_nxt     = e_r;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        e_nxt    = '0;
        if (in_xfer_w) state_nxt = S_ABC;
      end
      S_ABC: if (step_r == 6'd9) begin
        state_nxt = S_DISC;
        step_nxt  = '0;
      end
      S_DISC: if (step_r == 6'd7) begin
        state_nxt = (sum_w[ACC_W-1] || a_r == 64'd0) ? S_DONE : S_SQRT;
        step_nxt  = '0;
      end
      S_SQRT: if (step_r == 6'(ROOT_W - 1)) begin
        state_nxt = S_EMUL;
        step_nxt  = '0;
      end
      S_EMUL: if (step_r == 6'd1) begin
        state_nxt = S_EDIV;
        step_nxt  = '0;
      end
      S_EDIV: if (step_r == 6'd35) begin
        state_nxt = S_EFIN;
        step_nxt  = '0;
      end
      S_EFIN: begin
        step_nxt = '0;
        e_nxt    = e_r + 3'd1;
        state_nxt = (e_r == 3'd5) ? S_DONE : S_EMUL;
      end
      S_DONE: if (out_free_w) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      e_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      e_r     <= e_nxt;
      if (in_xfer_w && cnt_r < CNT_W'(LINE_CAPACITY)) cnt_r <= cnt_r + CNT_W'(1);
      if (state_r == S_DONE && out_free_w) out_valid_r <= 1'b1;
      else if (out_tready)                 out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer_w) begin
      for (int i = 0; i < 3; i++) begin
        px_r[i] <= in_tdata[32*i +: 32];
        qx_r[i] <= in_tdata[32*i+96 +: 32];
      end
      rad_r  <= in_tdata[222:192];
      k_r    <= k_w;
      full_r <= cnt_r >= CNT_W'(LINE_CAPACITY);
      idx_r  <= (cnt_r >= CNT_W'(LINE_CAPACITY)) ? 10'd0 : 10'(cnt_r);
      miss_r <= 1'b0;
      acc_r  <= '0;
    end
    unique case (state_r)
      S_ABC: begin
        if (step_r == 6'd2 || step_r == 6'd5 || step_r == 6'd9) acc_r <= '0;
        else                                                    acc_r <= sum_w;
        if (step_r == 6'd2) a_r <= sum_w[63:0];
        if (step_r == 6'd5) b_r <= sum_w[63:0];
        if (step_r == 6'd9) c_r <= sum_w[63:0];
      end
      S_DISC: begin
        acc_r  <= sum_w;
        rem_r  <= '0;
        root_r <= '0;
        if (step_r == 6'd7) miss_r <= sum_w[ACC_W-1] || a_r == 64'd0;
      end
      S_SQRT: begin
        // take one pair of radicand bits per step
        if (rge_w) begin
          rem_r  <= rdif_w;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= remt_w;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        if (step_r == 6'(ROOT_W - 1)) begin
          np_r  <= -{b_r[63], b_r} + 65'({root_r[ROOT_W-2:0], rge_w});
          nm_r  <= -{b_r[63], b_r} - 65'({root_r[ROOT_W-2:0], rge_w});
          acc_r <= ACC_W'(a_r >> 1);
        end else begin
          acc_r <= acc_r << 2;
        end
      end
      S_EMUL: begin
        acc_r <= sum_w;
        div_r <= DIV_W'(a_r) << 35;
        q_r   <= '0;
      end
      S_EDIV: begin
        div_r <= div_r >> 1;
        if (step_r == 6'd0) begin
          ovf_r <= !sum_w[ACC_W-1];
        end else begin
          q_r <= {q_r[33:0], !sum_w[ACC_W-1]};
          if (!sum_w[ACC_W-1]) acc_r <= sum_w;
        end
      end
      S_EFIN: begin
        res_r[e_r] <= sat_w;
        acc_r      <= ACC_W'(a_r >> 1);
      end
      default: ;
    endcase
    if (state_r == S_DONE && out_free_w) begin
      if (miss_r) begin
        for (int i = 0; i < 3; i++) begin
          out_data_r[32*i +: 32]    <= px_r[i];
          out_data_r[32*i+96 +: 32] <= qx_r[i];
        end
      end else begin
        for (int i = 0; i < 6; i++) out_data_r[32*i +: 32] <= res_r[i];
      end
      out_user_r <= {4'd0, full_r, idx_r, miss_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LINE_CAPACITY))
    else $error("line counter beyond capacity");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer_w |=> state_r == S_ABC && step_r == 6'd0)
    else $error("accepted line did not start the sequencer");
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> rem_r[65:64] == 2'b00)
    else $error("square root remainder overflow");
  a_ecnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMUL || state_r == S_EDIV || state_r == S_EFIN) |-> e_r <= 3'd5)
    else $error("endpoint index out of range");

endmodule
`default_nettype wire

// ===== tb/tb_line_sphere_clip_core.sv =====
`default_nettype none
module tb_line_sphere_clip_core;

  localparam int CAPACITY  = 1024;
  localparam int RAND_ITEMS = 1700;
  localparam int END_WAIT  = 400;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [31:0] MINC = 32'h8000_0000;

  typedef struct packed {
    logic [5:0][lsc_pkg::COORD_W-1:0] pt;  // first x,y,z then second x,y,z
    logic [lsc_pkg::RAD_W-1:0]        rad;
  } line_t;

  typedef struct packed {
    logic [5:0][lsc_pkg::COORD_W-1:0] ends;  // end a x,y,z then end b x,y,z
    logic                             miss;
    logic [9:0]                       idx;
    logic                             full;
  } clip_t;

  typedef struct {
    line_t ln;
    bit    known;
    clip_t want;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [223:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic [15:0]  out_tuser;

  clip_t pending_clips[$];
  row_t  dir_rows[$];
  int    line_cnt;
  int    err_cnt = 0;

  line_sphere_clip_core #(.LINE_CAPACITY(CAPACITY)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(64'd8 * 64'd4_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic logic [31:0] clip_coord(input longint xv, input longint vv,
                                             input longint n, input longint unsigned a);
    logic [127:0] p, q;
    longint res;
    p = 128'(mag(n)) * 128'(mag(vv)) + 128'(a >> 1);
    q = p / 128'(a);
    if (q > (128'(1) << lsc_pkg::QCAP_BIT)) q = 128'(1) << lsc_pkg::QCAP_BIT;
    res = ((n < 0) != (vv < 0)) ? xv - longint'(q[63:0]) : xv + longint'(q[63:0]);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  // crossings of the line with the sphere; advances the line counter below capacity
  function automatic clip_t clip_line(input line_t ln);
    longint x[3], v[3], xs[3], vs[3];
    longint rs, aa, bb, cc, np, nm;
    longint unsigned m;
    logic [127:0] b2, ac, d, sq, cand;
    int k, nb;
    bit miss;
    clip_t r;
    aa = 0; bb = 0; cc = 0; nb = 0; k = 0; d = '0;
    m = longint'(ln.rad);
    for (int i = 0; i < 3; i++) begin
      x[i] = longint'($signed(ln.pt[i]));
      v[i] = longint'($signed(ln.pt[i+3])) - x[i];
      if (mag(x[i]) > m) m = mag(x[i]);
      if (mag(v[i]) > m) m = mag(v[i]);
    end
    while (nb < 64 && (m >> nb) != 0) nb++;
    if (nb > 30) k = nb - 30;
    for (int i = 0; i < 3; i++) begin
      xs[i] = x[i] >>> k;
      vs[i] = v[i] >>> k;
      aa += vs[i] * vs[i];
      bb += xs[i] * vs[i];
      cc += xs[i] * xs[i];
    end
    rs = longint'(ln.rad) >>> k;
    cc -= rs * rs;
    miss = (aa == 0);
    if (!miss) begin
      b2 = 128'(mag(bb)) * 128'(mag(bb));
      ac = 128'(aa) * 128'(mag(cc));
      if (cc <= 0) d = b2 + ac;
      else if (b2 < ac) miss = 1'b1;
      else d = b2 - ac;
    end
    r.miss = miss;
    if (miss) begin
      r.ends = ln.pt;
    end else begin
      sq = '0;
      for (int b = lsc_pkg::ROOT_W - 1; b >= 0; b--) begin
        cand = sq | (128'(1) << b);
        if (cand * cand <= d) sq = cand;
      end
      np = -bb + longint'(sq[63:0]);
      nm = -bb - longint'(sq[63:0]);
      for (int i = 0; i < 3; i++) begin
        r.ends[i]   = clip_coord(x[i], v[i], np, aa);
        r.ends[i+3] = clip_coord(x[i], v[i], nm, aa);
      end
    end
    if (line_cnt >= CAPACITY) begin
      r.idx = '0;
      r.full = 1'b1;
    end else begin
      r.idx = line_cnt[9:0];
      r.full = 1'b0;
      line_cnt++;
    end
    return r;
  endfunction

  function automatic row_t mk_row(input logic [31:0] ax, ay, az, bx, by, bz,
                                  input logic [30:0] rad);
    row_t rw;
    rw.ln.pt = {bz, by, bx, az, ay, ax};
    rw.ln.rad = rad;
    rw.known = 1'b0;
    rw.want = '0;
    return rw;
  endfunction

  function automatic logic [31:0] rnd_span(input int unsigned half);
    return 32'($urandom_range(0, 2 * half)) - 32'(half);
  endfunction

  function automatic line_t rnd_line();
    line_t ln;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 6; i++) begin
      case (mode)
        0, 1:    ln.pt[i] = $urandom;
        9:       ln.pt[i] = rnd_span(32'h4000_0000);
        default: ln.pt[i] = rnd_span(32'h0040_0000);
      endcase
    end
    case (mode)
      0, 1, 9: ln.rad = 31'($urandom);
      default: ln.rad = 31'($urandom_range(0, 32'h0080_0000));
    endcase
    // equal points
    if (mode == 8) ln.pt[5:3] = ln.pt[2:0];
    return ln;
  endfunction

  // drive one line and hold it until the transfer completes
  task automatic send_line(input line_t ln, input bit known, input clip_t want);
    clip_t pred;
    in_tdata  <= {1'b0, ln.rad, ln.pt};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = clip_line(ln);
    pending_clips.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  int burst_left;

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // receiver stall pattern: long ready stretches mixed with choppy stalls
  int stall_phase = 0;
  always @(negedge clk) begin
    if (stall_phase == 0) stall_phase <= $urandom_range(1, 600);
    else stall_phase <= stall_phase - 1;
    if (stall_phase > 300) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    clip_t got, exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      got.ends = out_tdata;
      got.miss = out_tuser[0];
      got.idx  = out_tuser[10:1];
      got.full = out_tuser[11];
      if (pending_clips.size() == 0) begin
        $error("unexpected result transfer");
        err_cnt++;
      end else begin
        exp_c = pending_clips.pop_front();
        for (int i = 0; i < 6; i++)
          if (got.ends[i] !== exp_c.ends[i]) begin
            $error("%s_%s: expected %h, got %h", i < 3 ? "end_a" : "end_b",
                   (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z",
                   exp_c.ends[i], got.ends[i]);
            err_cnt++;
          end
        if (got.miss !== exp_c.miss) begin
          $error("missed_sphere: expected %b, got %b", exp_c.miss, got.miss);
          err_cnt++;
        end
        if (got.idx !== exp_c.idx) begin
          $error("line_index: expected %0d, got %0d", exp_c.idx, got.idx);
          err_cnt++;
        end
        if (got.full !== exp_c.full) begin
          $error("store_full: expected %b, got %b", exp_c.full, got.full);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    row_t rw;
    line_cnt = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;

    // equal points at the origin: passed through, index 0
    rw = mk_row(0, 0, 0, 0, 0, 0, 31'd0);
    rw.known = 1'b1;
    rw.want = '{ends: '0, miss: 1'b1, idx: 10'd0, full: 1'b0};
    dir_rows.push_back(rw);
    // equal points at the extremes
    rw = mk_row(MAXC, MINC, MAXC, MAXC, MINC, MAXC, 31'h7FFF_FFFF);
    rw.known = 1'b1;
    rw.want = '{ends: rw.ln.pt, miss: 1'b1, idx: 10'd1, full: 1'b0};
    dir_rows.push_back(rw);
    // line at x=10 never reaches a unit sphere
    rw = mk_row(10 * ONE, 0, 0, 10 * ONE, ONE, 0, ONE[30:0]);
    rw.known = 1'b1;
    rw.want = '{ends: rw.ln.pt, miss: 1'b1, idx: 10'd2, full: 1'b0};
    dir_rows.push_back(rw);
    // direction lost under the common shift
    rw = mk_row(32'h7FFF_FFFE, 0, 0, MAXC, 0, 0, 31'd0);
    rw.known = 1'b1;
    rw.want = '{ends: rw.ln.pt, miss: 1'b1, idx: 10'd3, full: 1'b0};
    dir_rows.push_back(rw);
    // tangent, through the center, and assorted extremes
    dir_rows.push_back(mk_row(ONE, -5 * ONE, 0, ONE, 5 * ONE, 0, ONE[30:0]));
    dir_rows.push_back(mk_row(-ONE, 0, 0, ONE, 0, 0, 31'(2 * ONE)));
    dir_rows.push_back(mk_row(0, 0, 0, 0, 0, ONE, 31'(3 * ONE)));
    dir_rows.push_back(mk_row(MINC, MINC, MINC, MAXC, MAXC, MAXC, 31'h7FFF_FFFF));
    dir_rows.push_back(mk_row(MAXC, MAXC, MAXC, MINC, MINC, MINC, 31'h7FFF_FFFF));
    dir_rows.push_back(mk_row(MINC, 0, 0, MAXC, 0, 0, 31'h7FFF_FFFF));
    dir_rows.push_back(mk_row(MINC, MAXC, 0, MAXC, MINC, 0, 31'd0));
    dir_rows.push_back(mk_row(0, 0, 0, MAXC, MAXC, MAXC, 31'h7FFF_FFFF));
    dir_rows.push_back(mk_row(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 31'h7FFF_FFFF));
    dir_rows.push_back(mk_row(3 * ONE, 4 * ONE, 0, 3 * ONE, 4 * ONE, ONE, 31'(5 * ONE)));
    dir_rows.push_back(mk_row(1, 0, 0, 0, 1, 0, 31'd1));
    dir_rows.push_back(mk_row(100 * ONE, 0, 0, 101 * ONE, 0, 0, ONE[30:0]));
    dir_rows.push_back(mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              0, 0, 0, 31'h7FFF_FFFF));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      pace();
      send_line(dir_rows[i].ln, dir_rows[i].known, dir_rows[i].want);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) begin
        // drain completely before resuming
        in_tvalid <= 1'b0;
        while (pending_clips.size() != 0) @(negedge clk);
      end
      pace();
      send_line(rnd_line(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_clips.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
